// ===== rtl/lbtk_pkg.sv =====
// Shared types and constants for the light budget top-k selector.
// Used by lbtk_ctrl, lbtk_datapath and light_budget_top_k_select.
`timescale 1ns / 1ps

package lbtk_pkg;

    localparam logic [30:0] REACH_FLOOR = 31'd66;
    localparam int KEY_W = 48;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    localparam logic [1:0] CFG_CAMERA_X = 2'd0;
    localparam logic [1:0] CFG_CAMERA_Y = 2'd1;
    localparam logic [1:0] CFG_CAMERA_Z = 2'd2;

    localparam logic RESULT_LOSER = 1'b0;
    localparam logic RESULT_KEPT  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request and start the distance math
        logic sq_step;    // compute squares and sum
        logic div_start;  // start the key divider
        logic insert;     // apply the insertion to the store
        logic emit_loser; // load the loser notice into the output register
        logic emit_kept;  // load the kept entry at the read index
        logic clear;      // clear store at frame end
    } lbtk_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic lose;
        logic fend;
        logic last_kept;  // every kept entry has been loaded for output
        logic any_kept;
    } lbtk_stat_t;

endpackage

// ===== rtl/light_budget_top_k_select.sv =====
// Top level of the light budget top-k selector.
// Instantiates lbtk_ctrl and lbtk_datapath; uses lbtk_pkg.
`timescale 1ns / 1ps

// A light request settles in the store after the ST_SQ, ST_DIVSTART, ST_DIV and
// ST_INSERT states; the bit-serial key divider gives one quotient bit per cycle
// (48 bits), and when the key saturates the divider is skipped. A request that
// causes no result returns the controller to idle. Each result is loaded into
// the output register and held until it is taken. A new request is accepted
// only after all results of the previous one are taken. The store holds
// LIGHT_BUDGET entries in flip-flops.

module light_budget_top_k_select
    import lbtk_pkg::*;
#(
    parameter int LIGHT_BUDGET = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // light_x, light_y, light_z, reach, brightness, rank_class, stack_tag,
    // owner_id, owner_drawn (200 bits)
    input  logic [199:0] s_axis_tdata,
    input  logic         s_axis_tlast,   // frame_end
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_owner, out_tag, mark_partial, out_rank, kept_total, dropped_total, pad
    output logic [63:0]  m_axis_tdata,
    output logic         m_axis_tuser,   // result_kind
    output logic         m_axis_tlast    // run_last
);

    lbtk_cmd_t  cmd;
    lbtk_stat_t stat;
    logic       in_fire, out_fire;
    logic       kind, partial;
    logic [15:0] own, tag, drop;
    logic [5:0]  rnk, kept;
    logic        last_flag;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fire  = m_axis_tvalid && m_axis_tready;

    lbtk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .stat      (stat),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (cmd)
    );

    lbtk_datapath #(.BUDGET(LIGHT_BUDGET)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_valid),
        .cfg_idx      (cfg_index),
        .cfg_value    (cfg_data),
        .light_x      (s_axis_tdata[31:0]),
        .light_y      (s_axis_tdata[63:32]),
        .light_z      (s_axis_tdata[95:64]),
        .reach        (s_axis_tdata[126:96]),
        .brightness   (s_axis_tdata[158:127]),
        .rank_class   (s_axis_tdata[166:159]),
        .stack_tag    (s_axis_tdata[182:167]),
        .owner_id     (s_axis_tdata[198:183]),
        .owner_drawn  (s_axis_tdata[199]),
        .frame_end    (s_axis_tlast),
        .result_kind  (kind),
        .out_owner    (own),
        .out_tag      (tag),
        .mark_partial (partial),
        .out_rank     (rnk),
        .kept_total   (kept),
        .dropped_total(drop)
    );

    // The last result: a kept entry of the final rank, or a loser that no kept entries follow.
    assign last_flag = (kind == RESULT_KEPT) ? (32'(rnk) + 1 == 32'(kept))
                     : !(stat.fend && stat.any_kept);

    assign m_axis_tdata = {3'd0, drop, kept, rnk, partial, tag, own};
    assign m_axis_tuser = kind;
    assign m_axis_tlast = last_flag;

endmodule

// ===== rtl/lbtk_ctrl.sv =====
// Controller state machine for the light budget top-k selector.
// Depends on lbtk_pkg; drives lbtk_datapath through lbtk_cmd_t.
`timescale 1ns / 1ps

module lbtk_ctrl
    import lbtk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       out_fire,
    input  lbtk_stat_t stat,
    output logic       in_ready,
    output logic       out_valid,
    output lbtk_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_DIVSTART,
        ST_DIV,
        ST_INSERT,
        ST_LOSER,
        ST_KEPT,
        ST_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    // Whether the waiting result is a kept entry (so more may follow).
    logic   kept_phase_reg, kept_phase_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        kept_phase_next = kept_phase_reg;
        cmd             = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                state_next  = ST_DIVSTART;
            end
            ST_DIVSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                    state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                if (stat.lose)
                    state_next = ST_LOSER;
                else if (stat.fend)
                    state_next = ST_KEPT;
                else
                    state_next = ST_IDLE;
            end
            ST_LOSER:
            begin
                cmd.emit_loser  = 1'b1;
                out_valid_next  = 1'b1;
                kept_phase_next = 1'b0;
                state_next      = ST_WAIT;
            end
            ST_KEPT:
            begin
                cmd.emit_kept   = 1'b1;
                out_valid_next  = 1'b1;
                kept_phase_next = 1'b1;
                state_next      = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (!kept_phase_reg && stat.fend && stat.any_kept)
                        state_next = ST_KEPT;
                    else if (kept_phase_reg && !stat.last_kept)
                        state_next = ST_KEPT;
                    else
                    begin
                        cmd.clear  = stat.fend;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            kept_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            kept_phase_reg <= kept_phase_next;
        end
    end

    a_ready_idle : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready)
        else $error("input taken while a result waits");
    a_valid_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_fire) |=> out_valid_reg)
        else $error("result dropped before taken");
    a_wait_valid : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> out_valid_reg)
        else $error("waiting with no result");

endmodule

// ===== rtl/lbtk_datapath.sv =====
// Datapath: distance and key arithmetic, serial divider, ranked store, output register.
// Depends on lbtk_pkg; commanded by lbtk_ctrl.
`timescale 1ns / 1ps

module lbtk_datapath
    import lbtk_pkg::*;
#(
    parameter int BUDGET = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lbtk_cmd_t          cmd,
    output lbtk_stat_t         stat,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic signed [31:0] cfg_value,
    input  logic signed [31:0] light_x,
    input  logic signed [31:0] light_y,
    input  logic signed [31:0] light_z,
    input  logic [30:0]        reach,
    input  logic signed [31:0] brightness,
    input  logic [7:0]         rank_class,
    input  logic [15:0]        stack_tag,
    input  logic [15:0]        owner_id,
    input  logic               owner_drawn,
    input  logic               frame_end,
    output logic               result_kind,
    output logic [15:0]        out_owner,
    output logic [15:0]        out_tag,
    output logic               mark_partial,
    output logic [5:0]         out_rank,
    output logic [5:0]         kept_total,
    output logic [15:0]        dropped_total
);

    localparam int IW = (BUDGET > 1) ? $clog2(BUDGET) : 1;
    localparam int CW = $clog2(BUDGET + 1);

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;

    // Captured request.
    logic [32:0] dx_reg, dy_reg, dz_reg;
    logic [30:0] reach_reg;
    logic [31:0] inten_reg;
    logic [7:0]  cls_reg;
    logic [15:0] tag_reg, owner_reg;
    logic        drawn_reg, fend_reg;

    logic [63:0] div_reg;  // divisor D
    logic [63:0] rem_reg;
    logic [KEY_W-1:0] q_reg;
    logic [5:0]  step_reg;
    logic        busy_reg, done_reg;

    logic [BUDGET-1:0] v_reg;
    logic [7:0]        s_cls [BUDGET];
    logic [KEY_W-1:0]  s_key [BUDGET];
    logic [15:0]       s_tag [BUDGET];
    logic [15:0]       s_own [BUDGET];
    logic              s_drw [BUDGET];
    logic [15:0]       seen_reg;
    // Counts kept entries already loaded for output.
    logic [CW-1:0]     rd_reg;
    logic              lose_reg;
    logic [15:0]       l_own_reg, l_tag_reg;
    logic              l_drw_reg;

    logic        kind_reg, part_reg;
    logic [15:0] oown_reg, otag_reg, drop_reg;
    logic [5:0]  orank_reg, okept_reg;

    function automatic logic [32:0] absdiff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [32:0] d;
        begin
            d = 33'(a) - 33'(b);
            absdiff = d[32] ? 33'(-d) : 33'(d);
        end
    endfunction

    // Squares: three 33x33 products summed with saturation.
    logic [65:0] sq_x, sq_y, sq_z;
    logic [67:0] sq_sum;
    logic [30:0] rfl;
    logic [61:0] rsq;
    logic [63:0] dsat;
    assign sq_x   = dx_reg * dx_reg;
    assign sq_y   = dy_reg * dy_reg;
    assign sq_z   = dz_reg * dz_reg;
    assign sq_sum = 68'(sq_x) + 68'(sq_y) + 68'(sq_z);
    assign rfl    = (reach_reg < REACH_FLOOR) ? REACH_FLOOR : reach_reg;
    assign rsq    = rfl * rfl;
    assign dsat   = (|sq_sum[67:64]) ? {64{1'b1}} : sq_sum[63:0];

    // Restoring divider step.
    logic [64:0] rem_sh;
    logic        take;
    assign rem_sh = {rem_reg, 1'b0};
    assign take   = (rem_sh >= 65'(div_reg));

    // Store comparison: first slot the new entry ranks ahead of.
    logic [BUDGET-1:0] ahead;
    logic [CW-1:0]     cnt, pos;
    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < BUDGET; i++)
            if (v_reg[i])
                cnt = CW'(i + 1);
        for (int i = 0; i < BUDGET; i++)
        begin
            if (s_cls[i] != cls_reg)
                ahead[i] = v_reg[i] && (cls_reg < s_cls[i]);
            else if (s_key[i] != q_reg)
                ahead[i] = v_reg[i] && (q_reg > s_key[i]);
            else
                ahead[i] = v_reg[i] && (tag_reg < s_tag[i]);
        end
        pos = cnt;
        for (int i = BUDGET - 1; i >= 0; i--)
            if (ahead[i])
                pos = CW'(i);
    end

    logic full;
    assign full = (cnt == CW'(BUDGET));

    logic [CW-1:0] cnt_after;
    assign cnt_after = cnt;

    assign stat.div_done  = done_reg;
    assign stat.lose      = full;
    assign stat.fend      = fend_reg;
    assign stat.last_kept = (rd_reg >= cnt);
    assign stat.any_kept  = (cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
            v_reg     <= '0;
            seen_reg  <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            rd_reg    <= '0;
            step_reg  <= '0;
            q_reg     <= '0;
            rem_reg   <= '0;
            lose_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_CAMERA_X: cam_x_reg <= cfg_value;
                    CFG_CAMERA_Y: cam_y_reg <= cfg_value;
                    CFG_CAMERA_Z: cam_z_reg <= cfg_value;
                    default: ;
                endcase
            end
            done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                step_reg <= '0;
                q_reg    <= '0;
                rem_reg  <= 64'(inten_reg);
                if (64'(inten_reg) >= div_reg)
                begin
                    q_reg    <= KEY_MAX;
                    done_reg <= 1'b1;
                end
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= take ? 64'(rem_sh - 65'(div_reg)) : rem_sh[63:0];
                q_reg    <= {q_reg[KEY_W-2:0], take};
                step_reg <= step_reg + 6'd1;
                if (step_reg == 6'(KEY_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            if (cmd.insert)
            begin
                rd_reg <= '0;
                if (full)
                begin
                    lose_reg <= 1'b1;
                    if (seen_reg != 16'hFFFF)
                        seen_reg <= seen_reg + 16'd1;
                end
                else
                    lose_reg <= 1'b0;
                if (!full)
                    v_reg[cnt[IW-1:0]] <= 1'b1;
            end
            if (cmd.emit_kept)
                rd_reg <= rd_reg + CW'(1);
            if (cmd.clear)
            begin
                v_reg    <= '0;
                seen_reg <= '0;
            end
        end
    end

    // Request capture, divisor, store payload shift and output register; valid bits are handled above.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg    <= absdiff(light_x, cam_x_reg);
            dy_reg    <= absdiff(light_y, cam_y_reg);
            dz_reg    <= absdiff(light_z, cam_z_reg);
            reach_reg <= reach;
            inten_reg <= brightness[31] ? 32'd0 : brightness;
            cls_reg   <= rank_class;
            tag_reg   <= stack_tag;
            owner_reg <= owner_id;
            drawn_reg <= owner_drawn;
            fend_reg  <= frame_end;
        end
        if (cmd.sq_step)
            div_reg <= (dsat < 64'(rsq)) ? 64'(rsq) : dsat;
        if (cmd.insert)
        begin
            if (full)
            begin
                if (pos < CW'(BUDGET))
                begin
                    l_own_reg <= s_own[BUDGET-1];
                    l_tag_reg <= s_tag[BUDGET-1];
                    l_drw_reg <= s_drw[BUDGET-1];
                end
                else
                begin
                    l_own_reg <= owner_reg;
                    l_tag_reg <= tag_reg;
                    l_drw_reg <= drawn_reg;
                end
            end
            for (int i = BUDGET - 1; i >= 0; i--)
            begin
                if (CW'(i) == pos)
                begin
                    s_cls[i] <= cls_reg;
                    s_key[i] <= q_reg;
                    s_tag[i] <= tag_reg;
                    s_own[i] <= owner_reg;
                    s_drw[i] <= drawn_reg;
                end
                else if (i > 0 && CW'(i) > pos)
                begin
                    s_cls[i] <= s_cls[i-1];
                    s_key[i] <= s_key[i-1];
                    s_tag[i] <= s_tag[i-1];
                    s_own[i] <= s_own[i-1];
                    s_drw[i] <= s_drw[i-1];
                end
            end
        end
        if (cmd.emit_loser)
        begin
            kind_reg  <= RESULT_LOSER;
            oown_reg  <= l_own_reg;
            otag_reg  <= l_tag_reg;
            part_reg  <= l_drw_reg;
            orank_reg <= '0;
            okept_reg <= 6'(cnt_after);
            drop_reg  <= seen_reg;
        end
        if (cmd.emit_kept)
        begin
            kind_reg  <= RESULT_KEPT;
            oown_reg  <= s_own[rd_reg[IW-1:0]];
            otag_reg  <= s_tag[rd_reg[IW-1:0]];
            part_reg  <= 1'b0;
            orank_reg <= 6'(rd_reg);
            okept_reg <= 6'(cnt_after);
            drop_reg  <= seen_reg;
        end
    end

    assign result_kind   = kind_reg;
    assign out_owner     = oown_reg;
    assign out_tag       = otag_reg;
    assign mark_partial  = part_reg;
    assign out_rank      = orank_reg;
    assign kept_total    = okept_reg;
    assign dropped_total = drop_reg;

    a_prefix : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> (v_reg & (v_reg + 1'b1)) == '0)
        else $error("valid slots not a prefix");
    a_div_len : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !done_reg || !busy_reg)
        else $error("divider busy and done together");
    a_lose_full : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_loser |-> lose_reg)
        else $error("loser emitted without a loss");

endmodule
